// ===== hdl/rsd_pkg.sv =====
// Shared types and constants for the run-length scanline decoder.
package rsd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RLE_MODE  = 2'd0;
    localparam logic [1:0] CFG_BYTES_PER = 2'd1;
    localparam logic [1:0] CFG_CHAN_CNT  = 2'd2;
    localparam logic [1:0] CFG_LINE_WID  = 2'd3;

    // Reset values of the configuration registers
    localparam logic        RST_RLE_MODE  = 1'b1;
    localparam logic [1:0]  RST_BYTES_PER = 2'd1;
    localparam logic [2:0]  RST_CHAN_CNT  = 3'd1;
    localparam logic [15:0] RST_LINE_WID  = 16'd512;

    // Header element layout
    localparam int unsigned LITERAL_BIT = 7;
    localparam int unsigned COUNT_BITS  = 7;
    localparam logic [1:0]  TWO_BYTES   = 2'd2;

    typedef enum logic [1:0] {
        PM_HEADER  = 2'd0,
        PM_LITERAL = 2'd1,
        PM_REPEAT  = 2'd2,
        PM_DONE    = 2'd3
    } t_parse_mode;

    typedef struct packed {
        logic        rle_mode;
        logic [1:0]  bytes_per_component;
        logic [2:0]  channel_count;
        logic [15:0] line_width;
    } t_cfg;

    typedef struct packed {
        t_parse_mode     mode;
        logic [COUNT_BITS-1:0] remaining;
        logic            phase;
        logic [15:0]     column;
    } t_state;

    typedef struct packed {
        logic [7:0] code_byte;
        logic [1:0] channel;
        logic       line_start;
    } t_item;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [15:0] start_column;
        logic [17:0] buffer_index;
        logic [6:0]  run_length;
        logic        line_end;
        logic        overrun;
    } t_result;

endpackage

// ===== hdl/rsd_decode.sv =====
// Combinational decode of one code byte: next parser state and result.
module rsd_decode import rsd_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output logic    o_emit,
    output t_result o_result
);

    t_state                eff;
    logic                  two;
    logic                  phase;
    logic [COUNT_BITS-1:0] hdr_count;
    logic [COUNT_BITS-1:0] run_count;
    logic [15:0]           avail;
    logic                  clip;
    logic [6:0]            run_len;
    logic [16:0]           col_inc;
    logic                  vb_end;
    logic [18:0]           prod;

    // Line start clears the parser before the byte is handled
    always_comb begin
        eff = i_state;
        if (i_item.line_start) begin
            eff.mode      = PM_HEADER;
            eff.remaining = '0;
            eff.phase     = 1'b0;
            eff.column    = '0;
        end
    end

    assign two       = (i_cfg.bytes_per_component == TWO_BYTES);
    assign phase     = two & eff.phase;
    assign hdr_count = i_item.code_byte[COUNT_BITS-1:0];
    assign run_count = (eff.mode == PM_LITERAL) ? COUNT_BITS'(1) : eff.remaining;
    assign avail     = (eff.column < i_cfg.line_width) ? (i_cfg.line_width - eff.column)
                                                       : 16'd0;
    assign clip      = ({9'd0, run_count} > avail);
    assign run_len   = clip ? avail[6:0] : run_count;
    assign col_inc   = {1'b0, eff.column} + 17'd1;
    assign vb_end    = (col_inc >= {1'b0, i_cfg.line_width});
    assign prod      = 19'(eff.column) * 19'(i_cfg.channel_count);

    // Next state
    always_comb begin
        o_state       = eff;
        o_state.phase = two & ~phase;
        if (eff.mode != PM_DONE) begin
            if (!i_cfg.rle_mode) begin
                if (!phase) begin
                    o_state.column = col_inc[15:0];
                    if (vb_end) begin
                        o_state.mode = PM_DONE;
                    end
                end
            end else if (eff.mode == PM_HEADER) begin
                if (!two || phase) begin
                    if (hdr_count == '0) begin
                        o_state.mode = PM_DONE;
                    end else begin
                        o_state.remaining = hdr_count;
                        o_state.mode = i_item.code_byte[LITERAL_BIT] ? PM_LITERAL
                                                                     : PM_REPEAT;
                    end
                end
            end else if (!phase) begin
                o_state.column = eff.column + {9'd0, run_len};
                if (eff.mode == PM_LITERAL) begin
                    o_state.remaining = eff.remaining - COUNT_BITS'(1);
                    if (eff.remaining == COUNT_BITS'(1)) begin
                        o_state.mode = PM_HEADER;
                    end
                end else begin
                    o_state.remaining = '0;
                    o_state.mode      = PM_HEADER;
                end
            end
        end
    end

    // Result
    always_comb begin
        o_emit                = 1'b0;
        o_result.pixel_value  = i_item.code_byte;
        o_result.start_column = eff.column;
        o_result.buffer_index = prod[17:0] + 18'(i_item.channel);
        o_result.run_length   = 7'd1;
        o_result.line_end     = 1'b0;
        o_result.overrun      = 1'b0;
        if (eff.mode != PM_DONE) begin
            if (!i_cfg.rle_mode) begin
                o_emit            = ~phase;
                o_result.line_end = vb_end;
            end else if (eff.mode == PM_HEADER) begin
                if ((!two || phase) && hdr_count == '0) begin
                    o_emit                = 1'b1;
                    o_result.pixel_value  = 8'd0;
                    o_result.run_length   = 7'd0;
                    o_result.line_end     = 1'b1;
                end
            end else begin
                o_emit              = ~phase;
                o_result.run_length = run_len;
                o_result.overrun    = clip;
            end
        end
    end

endmodule

// ===== hdl/rsd_out_reg.sv =====
// Result register with valid/stall handshake toward the consumer.
module rsd_out_reg import rsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Free when empty or its content transfers this cycle
    assign o_ready = ~r_valid | ~i_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hdl/rle_scanline_decoder_unit.sv =====
// Top level of the run-length / verbatim channel scanline decoder.
// Path: a code byte that transfers in is held in the input register, then decoded
//   into the result register, where its result is presented (two register stages).
// Throughput: one code byte per cycle; the input stalls only while a result
//   waits in the stalled result register and the byte in the input register emits.
// Reset (i_rst_n low, synchronous): pipeline valids drop, parser goes to header
//   state at column 0, config registers return to their defaults.
module rle_scanline_decoder_unit import rsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // code byte stream
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_code_byte,
    input  logic [1:0]  i_channel,
    input  logic        i_line_start,
    // decoded results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pixel_value,
    output logic [15:0] o_start_column,
    output logic [17:0] o_buffer_index,
    output logic [6:0]  o_run_length,
    output logic        o_line_end,
    output logic        o_overrun,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    logic    r_s1_valid;
    logic    n_s1_valid;
    t_item   r_s1_item;
    logic    emit;
    t_result result;
    t_result out_result;
    logic    out_ready;
    logic    s1_fire;
    logic    in_xfer;

    // Config regs always ready; host must write only while no byte in flight (unenforced)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rle_mode            <= RST_RLE_MODE;
            r_cfg.bytes_per_component <= RST_BYTES_PER;
            r_cfg.channel_count       <= RST_CHAN_CNT;
            r_cfg.line_width          <= RST_LINE_WID;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RLE_MODE:  r_cfg.rle_mode            <= i_cfg_data[0];
                CFG_BYTES_PER: r_cfg.bytes_per_component <= i_cfg_data[1:0];
                CFG_CHAN_CNT:  r_cfg.channel_count       <= i_cfg_data[2:0];
                CFG_LINE_WID:  r_cfg.line_width          <= i_cfg_data;
                default:       r_cfg                     <= r_cfg;
            endcase
        end
    end

    // Stage 1 retires when it makes no result or the result register is free.
    // Parser state advances exactly on that retire, so bytes stay in order.
    assign s1_fire    = r_s1_valid & (~emit | out_ready);
    assign o_in_stall = r_s1_valid & ~s1_fire;
    assign in_xfer    = i_in_valid & ~o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_xfer) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item.code_byte  <= i_code_byte;
            r_s1_item.channel    <= i_channel;
            r_s1_item.line_start <= i_line_start;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= PM_HEADER;
            r_state.remaining <= '0;
            r_state.phase     <= 1'b0;
            r_state.column    <= '0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    rsd_decode u_decode (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_s1_item),
        .o_state  (n_state),
        .o_emit   (emit),
        .o_result (result)
    );

    // Result register decouples consumer stall from the byte stream
    rsd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_s1_valid & emit),
        .i_result (result),
        .i_stall  (i_out_stall),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_pixel_value  = out_result.pixel_value;
    assign o_start_column = out_result.start_column;
    assign o_buffer_index = out_result.buffer_index;
    assign o_run_length   = out_result.run_length;
    assign o_line_end     = out_result.line_end;
    assign o_overrun      = out_result.overrun;

endmodule

// ===== hdl/rsd_checker.sv =====
// Port-level checks for the scanline decoder, bound to the top level.
module rsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_code_byte,
    input logic [1:0]  i_channel,
    input logic        i_line_start,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_pixel_value,
    input logic [15:0] o_start_column,
    input logic [17:0] o_buffer_index,
    input logic [6:0]  o_run_length,
    input logic        o_line_end,
    input logic        o_overrun,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    // A stalled result holds until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_value)
            && $stable(o_start_column) && $stable(o_run_length)
            && $stable(o_buffer_index) && $stable(o_line_end) && $stable(o_overrun))
        else $error("result changed while stalled");

    // Zero length only for the end marker or a fully clipped run
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_run_length == 7'd0 |-> o_line_end || o_overrun)
        else $error("empty run without end or overrun");

    // Line end carries at most one column and never a clip
    a_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_end |-> o_run_length <= 7'd1 && !o_overrun)
        else $error("bad line end result");

    // Nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind rle_scanline_decoder_unit rsd_checker u_rsd_checker (.*);

// ===== dv/rle_scanline_decoder_unit_tb.sv =====
// Self-checking testbench for the run-length / verbatim scanline decoder.
module rle_scanline_decoder_unit_tb;
    import rsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Drain window: two-stage pipeline plus margin, so header bytes that
    // produce nothing have left the block before the next config write.
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_code_byte = '0;
    logic [1:0]  i_channel = '0;
    logic        i_line_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_pixel_value;
    logic [15:0] o_start_column;
    logic [17:0] o_buffer_index;
    logic [6:0]  o_run_length;
    logic        o_line_end;
    logic        o_overrun;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    rle_scanline_decoder_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_code_byte    (i_code_byte),
        .i_channel      (i_channel),
        .i_line_start   (i_line_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_value  (o_pixel_value),
        .o_start_column (o_start_column),
        .o_buffer_index (o_buffer_index),
        .o_run_length   (o_run_length),
        .o_line_end     (o_line_end),
        .o_overrun      (o_overrun),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder shadow: config copy, parser state, and results still owed.
    // ------------------------------------------------------------------
    t_cfg    cfg_shadow = '{rle_mode: RST_RLE_MODE, bytes_per_component: RST_BYTES_PER,
                            channel_count: RST_CHAN_CNT, line_width: RST_LINE_WID};
    t_state  parser = '{mode: PM_HEADER, remaining: '0, phase: 1'b0, column: '0};
    t_result pending_pixels[$];

    int n_errors = 0;
    int n_live_bytes = 0;   // bytes that reached the parser (not swallowed after line end)

    // Idle knobs, percent per cycle
    int in_idle_pct = 0;
    int out_stall_pct = 0;

    // Long receiver hold-off: bump hold_req to start one
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic t_result pack_pixel(input logic [1:0] chan, input logic [7:0] value,
                                           input logic [6:0] len, input logic fin,
                                           input logic over);
        t_result r;
        logic [31:0] idx;
        idx = 32'(parser.column) * 32'(cfg_shadow.channel_count) + 32'(chan);
        r.pixel_value  = value;
        r.start_column = parser.column;
        r.buffer_index = idx[17:0];
        r.run_length   = len;
        r.line_end     = fin;
        r.overrun      = over;
        return r;
    endfunction

    // Advance the shadow parser by one code byte; returns 1 when a result (pixel run or end marker) comes out.
    function automatic bit decode_code_byte(input t_item it, output t_result r);
        logic        two;
        logic        ph;
        logic        fin;
        logic [6:0]  cnt;
        logic [15:0] avail;
        logic [15:0] len;
        r = '0;
        two = (cfg_shadow.bytes_per_component == TWO_BYTES);
        if (it.line_start) begin
            parser.column    = '0;
            parser.mode      = PM_HEADER;
            parser.remaining = '0;
            parser.phase     = 1'b0;
        end
        ph = two ? parser.phase : 1'b0;
        parser.phase = two ? ~ph : 1'b0;
        if (parser.mode == PM_DONE)
            return 0;
        n_live_bytes++;

        // verbatim: first byte of each component is a pixel, line ends at width
        if (!cfg_shadow.rle_mode) begin
            if (ph)
                return 0;
            fin = (({1'b0, parser.column} + 17'd1) >= {1'b0, cfg_shadow.line_width});
            r = pack_pixel(it.channel, it.code_byte, 7'd1, fin, 1'b0);
            parser.column += 16'd1;
            if (fin)
                parser.mode = PM_DONE;
            return 1;
        end

        // header: count in second byte for two-byte elements
        if (parser.mode == PM_HEADER) begin
            if (two && !ph)
                return 0;
            if (it.code_byte[COUNT_BITS-1:0] == '0) begin
                r = pack_pixel(it.channel, 8'd0, 7'd0, 1'b1, 1'b0);
                parser.mode = PM_DONE;
                return 1;
            end
            parser.remaining = it.code_byte[COUNT_BITS-1:0];
            parser.mode = it.code_byte[LITERAL_BIT] ? PM_LITERAL : PM_REPEAT;
            return 0;
        end

        if (ph)
            return 0;
        cnt = (parser.mode == PM_LITERAL) ? 7'd1 : parser.remaining;
        avail = (parser.column < cfg_shadow.line_width) ?
                (cfg_shadow.line_width - parser.column) : 16'd0;
        len = ({9'd0, cnt} > avail) ? avail : {9'd0, cnt};
        r = pack_pixel(it.channel, it.code_byte, len[6:0], 1'b0, ({9'd0, cnt} > avail));
        parser.column += len;
        if (parser.mode == PM_LITERAL) begin
            parser.remaining -= 7'd1;
            if (parser.remaining == '0)
                parser.mode = PM_HEADER;
        end else begin
            parser.remaining = '0;
            parser.mode = PM_HEADER;
        end
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every output transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                note_error($sformatf("unexpected result value=%0h col=%0d len=%0d",
                                     o_pixel_value, o_start_column, o_run_length));
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_value !== want.pixel_value)
                    note_error($sformatf("pixel_value exp %0h got %0h",
                                         want.pixel_value, o_pixel_value));
                if (o_start_column !== want.start_column)
                    note_error($sformatf("start_column exp %0d got %0d",
                                         want.start_column, o_start_column));
                if (o_buffer_index !== want.buffer_index)
                    note_error($sformatf("buffer_index exp %0d got %0d",
                                         want.buffer_index, o_buffer_index));
                if (o_run_length !== want.run_length)
                    note_error($sformatf("run_length exp %0d got %0d",
                                         want.run_length, o_run_length));
                if (o_line_end !== want.line_end)
                    note_error($sformatf("line_end exp %0b got %0b",
                                         want.line_end, o_line_end));
                if (o_overrun !== want.overrun)
                    note_error($sformatf("overrun exp %0b got %0b",
                                         want.overrun, o_overrun));
            end
        end
    end

    // Receiver: random stalls, or a solid hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plumbing
    // ------------------------------------------------------------------

    // One code byte transfer; valid stays up afterwards so back-to-back bytes stream.
    task automatic send_byte(input logic [7:0] code, input logic [1:0] chan, input logic start);
        t_item   it;
        t_result r;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_code_byte  <= code;
        i_channel    <= chan;
        i_line_start <= start;
        do @(posedge i_clk); while (o_in_stall);
        it = '{code_byte: code, channel: chan, line_start: start};
        if (decode_code_byte(it, r))
            pending_pixels.push_back(r);
    endtask

    // One stored element: header count sits in the second byte, a value in the
    // first, when components are two bytes wide.
    task automatic send_elem(input logic [7:0] b, input logic is_header,
                             input logic [1:0] chan, input logic start);
        if (cfg_shadow.bytes_per_component == TWO_BYTES) begin
            if (is_header) begin
                send_byte(8'($urandom_range(255)), chan, start);
                send_byte(b, chan, 1'b0);
            end else begin
                send_byte(b, chan, start);
                send_byte(8'($urandom_range(255)), chan, 1'b0);
            end
        end else begin
            send_byte(b, chan, start);
        end
    endtask

    // Input goes quiet until every owed result has transferred, then the pipe settles.
    task automatic wait_for_pending();
        i_in_valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending_pixels.size() != 0; k++)
            @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            note_error($sformatf("%0d results never arrived", pending_pixels.size()));
            pending_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RLE_MODE:  cfg_shadow.rle_mode            = data[0];
            CFG_BYTES_PER: cfg_shadow.bytes_per_component = data[1:0];
            CFG_CHAN_CNT:  cfg_shadow.channel_count       = data[2:0];
            CFG_LINE_WID:  cfg_shadow.line_width          = data;
            default: ;
        endcase
    endtask

    // All four registers back to back; caller makes sure the block is idle.
    task automatic set_config(input logic rle, input logic [1:0] bpc,
                              input logic [2:0] chans, input logic [15:0] width);
        write_reg(CFG_RLE_MODE, {15'd0, rle});
        write_reg(CFG_BYTES_PER, {14'd0, bpc});
        write_reg(CFG_CHAN_CNT, {13'd0, chans});
        write_reg(CFG_LINE_WID, width);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_rle_line(input logic [1:0] chan, input logic terminate);
        int   n_pkts;
        int   cnt;
        logic lit;
        logic first;
        first = 1'b1;
        n_pkts = $urandom_range(1, 6);
        repeat (n_pkts) begin
            lit = 1'($urandom_range(1));
            if ($urandom_range(24) == 0)
                cnt = $urandom_range(1, 127);
            else
                cnt = lit ? $urandom_range(1, 8) : $urandom_range(1, 127);
            send_elem({lit, 7'(cnt)}, 1'b1, chan, first);
            first = 1'b0;
            if (lit)
                repeat (cnt) send_elem(8'($urandom_range(255)), 1'b0, chan, 1'b0);
            else
                send_elem(8'($urandom_range(255)), 1'b0, chan, 1'b0);
        end
        // end marker: zero count, flag bit either way
        if (terminate)
            send_elem({1'($urandom_range(1)), 7'd0}, 1'b1, chan, 1'b0);
        // trailing bytes are swallowed until the next line start
        repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), chan, 1'b0);
    endtask

    task automatic send_verbatim_line(input logic [1:0] chan);
        int n;
        if (cfg_shadow.line_width <= 16'd40)
            n = int'(cfg_shadow.line_width) + $urandom_range(0, 2);
        else
            n = $urandom_range(1, 30);
        if (n == 0)
            n = 1;
        for (int k = 0; k < n; k++)
            send_elem(8'($urandom_range(255)), 1'b0, chan, (k == 0));
    endtask

    // Garbage: random bytes with stray line starts, possibly mid-packet.
    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_byte(8'($urandom_range(255)), 2'($urandom_range(3)),
                      ($urandom_range(3) == 0));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built lines: literal and repeat packets, end marker, clipping,
    // two-byte elements, verbatim line end, zero width, odd channel counts.
    task automatic test_directed_runs();
        // reset config: run-length, one byte, one channel, width 512
        send_byte(8'h82, 2'd0, 1'b1);   // literal x2
        send_byte(8'h00, 2'd0, 1'b0);
        send_byte(8'hFF, 2'd0, 1'b0);
        send_byte(8'h7F, 2'd0, 1'b0);   // repeat x127
        send_byte(8'hAB, 2'd0, 1'b0);
        send_byte(8'h00, 2'd0, 1'b0);   // end of line
        send_byte(8'h55, 2'd0, 1'b0);   // swallowed

        // narrow line, zero channel count: repeat clipped, then nothing left
        wait_for_pending();
        set_config(1'b1, 2'd1, 3'd0, 16'd3);
        send_byte(8'h05, 2'd3, 1'b1);
        send_byte(8'h11, 2'd3, 1'b0);
        send_byte(8'h81, 2'd3, 1'b0);
        send_byte(8'h22, 2'd3, 1'b0);
        send_byte(8'h00, 2'd3, 1'b0);

        // two-byte elements: count from the second byte, value from the first
        wait_for_pending();
        set_config(1'b1, TWO_BYTES, 3'd2, 16'd100);
        send_byte(8'hEE, 2'd2, 1'b1);
        send_byte(8'h81, 2'd2, 1'b0);
        send_byte(8'h7A, 2'd2, 1'b0);
        send_byte(8'h00, 2'd2, 1'b0);
        send_byte(8'h13, 2'd2, 1'b0);
        send_byte(8'h00, 2'd2, 1'b0);

        // verbatim, width 2, seven channels: line ends on the second pixel
        wait_for_pending();
        set_config(1'b0, 2'd1, 3'd7, 16'd2);
        send_byte(8'h01, 2'd1, 1'b1);
        send_byte(8'h02, 2'd1, 1'b0);
        send_byte(8'h03, 2'd1, 1'b0);

        // zero width, verbatim: done after the first pixel
        wait_for_pending();
        set_config(1'b0, TWO_BYTES, 3'd4, 16'd0);
        send_byte(8'h80, 2'd0, 1'b1);
        send_byte(8'h7F, 2'd0, 1'b0);

        // zero width, run-length: every run clipped to nothing
        wait_for_pending();
        set_config(1'b1, 2'd1, 3'd1, 16'd0);
        send_byte(8'h03, 2'd1, 1'b1);
        send_byte(8'h44, 2'd1, 1'b0);
        send_byte(8'h00, 2'd1, 1'b0);
    endtask

    // Random configs, each with a few lines; mostly well-formed, some broken.
    task automatic test_random_lines(input int n_bytes);
        int          stop_at;
        logic        rle;
        logic [1:0]  bpc;
        logic [2:0]  chans;
        logic [15:0] width;
        stop_at = n_live_bytes + n_bytes;
        while (n_live_bytes < stop_at) begin
            rle = ($urandom_range(3) != 0);
            case ($urandom_range(9))
                0: bpc = 2'd0;
                1: bpc = 2'd3;
                2, 3, 4, 5: bpc = 2'd1;
                default: bpc = TWO_BYTES;
            endcase
            chans = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
            case ($urandom_range(9))
                0: width = 16'($urandom_range(1));
                1: width = 16'hFFFF;
                2: width = 16'($urandom_range(65535));
                default: width = 16'($urandom_range(1, 40));
            endcase
            wait_for_pending();
            set_config(rle, bpc, chans, width);
            repeat ($urandom_range(2, 4)) begin
                if ($urandom_range(4) == 0)
                    send_noise();
                else if (rle)
                    send_rle_line(2'($urandom_range(3)), ($urandom_range(9) != 0));
                else
                    send_verbatim_line(2'($urandom_range(3)));
            end
        end
    endtask

    // Long line, seven channels: column passes 32767 and the index wraps 18 bits.
    task automatic test_buffer_index_wrap();
        wait_for_pending();
        set_config(1'b1, 2'd1, 3'd7, 16'hFFFF);
        for (int k = 0; k < 300; k++) begin
            send_byte(8'h7F, 2'd3, (k == 0));
            send_byte(8'($urandom_range(255)), 2'd3, 1'b0);
        end
        send_byte(8'h80, 2'd3, 1'b0);
    endtask

    // Receiver holds off while every byte yields a pixel: the pipe fills and
    // must stall its input without losing or reordering anything.
    task automatic test_output_backpressure();
        wait_for_pending();
        set_config(1'b0, 2'd1, 3'd2, 16'd200);
        hold_req <= hold_req + 1;
        for (int k = 0; k < 160; k++)
            send_byte(8'($urandom_range(255)), 2'd1, (k == 0));
        wait_for_pending();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_runs();

        in_idle_pct = 7;
        out_stall_pct = 52;
        test_random_lines(300);

        in_idle_pct = 52;
        out_stall_pct = 7;
        test_random_lines(300);

        in_idle_pct = 0;
        out_stall_pct = 0;
        test_buffer_index_wrap();
        test_output_backpressure();
        test_random_lines(300);

        wait_for_pending();
        if (n_errors == 0) begin
            $display("rle_scanline_decoder_unit verification clean");
        end else begin
            $display("rle_scanline_decoder_unit verification failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("rle_scanline_decoder_unit verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rsd_pkg.sv
hdl/rsd_decode.sv
hdl/rsd_out_reg.sv
hdl/rle_scanline_decoder_unit.sv
hdl/rsd_checker.sv
dv/rle_scanline_decoder_unit_tb.sv
